// ----- rtl/pbct_pkg.sv -----
package pbct_pkg;

    localparam int POS_W = 16;
    localparam int COEFF_W = 16;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: signed 25-bit operand times a 16-bit unsigned
    // coefficient carried as a 17-bit signed value.
    localparam int CHUNK_W = 24;
    localparam int OPA_W = CHUNK_W + 1;
    localparam int OPB_W = COEFF_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;

    localparam int DP_W = POS_W + 2;
    localparam int DD_W = DP_W + 1;

    localparam int F_SHIFT = 16;
    localparam int G_SHIFT = 12;

    // floor(x / 3) = (x * 43691) >> 17 for every x below 2^17.
    localparam logic [OPB_W-1:0] RECIP3 = 17'd43691;
    localparam int RECIP3_SHIFT = 17;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MAC_LAST = 4'd11;

    localparam logic [POS_W-1:0] CELL_SIZE_REF_RST = 16'd2048;
    localparam logic [COEFF_W-1:0] FREQ_GAIN_RST = 16'd4096;
    localparam logic [COEFF_W-1:0] ERR_P_RST = 16'd8192;
    localparam logic [COEFF_W-1:0] ERR_I_RST = 16'd2048;
    localparam logic [COEFF_W-1:0] ERR_D_RST = 16'd1024;
    localparam logic [COEFF_W-1:0] DIFF_P_RST = 16'd512;
    localparam logic [COEFF_W-1:0] DIFF_I_RST = 16'd512;
    localparam logic [COEFF_W-1:0] DIFF_D_RST = 16'd1024;
    localparam logic [POS_W-1:0] SIZE_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_SIZE_REF = 3'd0,
        REG_FREQ_GAIN     = 3'd1,
        REG_ERR_P         = 3'd2,
        REG_ERR_I         = 3'd3,
        REG_ERR_D         = 3'd4,
        REG_DIFF_P        = 3'd5,
        REG_DIFF_I        = 3'd6,
        REG_DIFF_D        = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_INTEG,
        ST_MAC,
        ST_SUM,
        ST_CLAMP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DP,
        OP_DD,
        OP_DILO,
        OP_DIHI,
        OP_EP,
        OP_ED,
        OP_EILO,
        OP_EIHI,
        OP_GLO,
        OP_GHI,
        OP_LIM
    } op_t;

    typedef enum logic [1:0] {
        ACC_F,
        ACC_E,
        ACC_G,
        ACC_LIM
    } acc_sel_t;

    typedef struct packed {
        logic     en;
        acc_sel_t dest;
        logic     load;
        logic     sub;
        logic     hi;
    } mac_ctrl_t;

    typedef struct packed {
        logic ready;
        logic wrap;
        logic integ;
        op_t  op;
        logic sum;
        logic commit;
    } seq_ctrl_t;

    function automatic op_t mac_op(input logic [CNT_W-1:0] cnt);
        op_t op;
        case (cnt)
            4'd0:    op = OP_DP;
            4'd1:    op = OP_DD;
            4'd2:    op = OP_DILO;
            4'd3:    op = OP_DIHI;
            4'd4:    op = OP_EP;
            4'd5:    op = OP_ED;
            4'd6:    op = OP_EILO;
            4'd7:    op = OP_EIHI;
            4'd8:    op = OP_GLO;
            4'd9:    op = OP_GHI;
            4'd10:   op = OP_LIM;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic mac_ctrl_t op_ctrl(input op_t op);
        mac_ctrl_t c;
        c = '{en: 1'b1, dest: ACC_F, load: 1'b0, sub: 1'b0, hi: 1'b0};
        case (op)
            OP_DP:   c.load = 1'b1;
            OP_DD:   c.sub = 1'b1;
            OP_DILO: c.dest = ACC_F;
            OP_DIHI: c.hi = 1'b1;
            OP_EP: begin
                c.dest = ACC_E;
                c.load = 1'b1;
            end
            OP_ED: begin
                c.dest = ACC_E;
                c.sub = 1'b1;
            end
            OP_EILO: c.dest = ACC_E;
            OP_EIHI: begin
                c.dest = ACC_E;
                c.hi = 1'b1;
            end
            OP_GLO: begin
                c.dest = ACC_G;
                c.load = 1'b1;
            end
            OP_GHI: begin
                c.dest = ACC_G;
                c.hi = 1'b1;
            end
            OP_LIM:  c.dest = ACC_LIM;
            default: c.en = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/pbct_mac.sv -----
module pbct_mac #(
    parameter int ACC_W = 52
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pbct_pkg::op_t                        op,
    input  logic signed [pbct_pkg::OPA_W-1:0]    opa,
    input  logic signed [pbct_pkg::OPB_W-1:0]    opb,
    output logic signed [ACC_W-1:0]              acc_f,
    output logic signed [ACC_W-1:0]              acc_e,
    output logic signed [ACC_W-1:0]              acc_g,
    output logic [pbct_pkg::POS_W-1:0]           lim_lo
);
    import pbct_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctrl_t pctl_reg;
    logic signed [ACC_W-1:0] acc_f_reg, acc_f_next;
    logic signed [ACC_W-1:0] acc_e_reg, acc_e_next;
    logic signed [ACC_W-1:0] acc_g_reg, acc_g_next;
    logic [POS_W-1:0] lim_lo_reg, lim_lo_next;
    logic signed [ACC_W-1:0] term_ext;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum;

    // Product is registered together with what to do with it next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= opa * opb;
        if (!aresetn) begin
            pctl_reg <= '0;
        end else begin
            pctl_reg <= op_ctrl(op);
        end
    end

    always_comb begin
        term_ext = ACC_W'(prod_reg);
        term = pctl_reg.hi ? (term_ext <<< CHUNK_W) : term_ext;
        case (pctl_reg.dest)
            ACC_F:   base = acc_f_reg;
            ACC_E:   base = acc_e_reg;
            default: base = acc_g_reg;
        endcase
        if (pctl_reg.load) begin
            base = '0;
        end
        sum = pctl_reg.sub ? (base - term) : (base + term);

        acc_f_next = acc_f_reg;
        acc_e_next = acc_e_reg;
        acc_g_next = acc_g_reg;
        lim_lo_next = lim_lo_reg;
        if (pctl_reg.en) begin
            case (pctl_reg.dest)
                ACC_F:   acc_f_next = sum;
                ACC_E:   acc_e_next = sum;
                ACC_G:   acc_g_next = sum;
                default: lim_lo_next = prod_reg[RECIP3_SHIFT +: POS_W];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_f_reg <= acc_f_next;
        acc_e_reg <= acc_e_next;
        acc_g_reg <= acc_g_next;
        lim_lo_reg <= lim_lo_next;
    end

    assign acc_f = acc_f_reg;
    assign acc_e = acc_e_reg;
    assign acc_g = acc_g_reg;
    assign lim_lo = lim_lo_reg;

endmodule

// ----- rtl/pbct_seq.sv -----
module pbct_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic                   out_free,
    output pbct_pkg::seq_ctrl_t    ctrl
);
    import pbct_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:  state_next = ST_INTEG;
            ST_INTEG: begin
                state_next = ST_MAC;
                cnt_next = '0;
            end
            ST_MAC: begin
                if (cnt_reg == MAC_LAST) begin
                    state_next = ST_SUM;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{ready: 1'b0, wrap: 1'b0, integ: 1'b0, op: OP_NONE,
                 sum: 1'b0, commit: 1'b0};
        case (state_reg)
            ST_IDLE:  ctrl.ready = 1'b1;
            ST_WRAP:  ctrl.wrap = 1'b1;
            ST_INTEG: ctrl.integ = 1'b1;
            ST_MAC:   ctrl.op = mac_op(cnt_reg);
            ST_SUM:   ctrl.sum = 1'b1;
            ST_CLAMP: ctrl.commit = out_free;
            default:  ctrl.ready = 1'b0;
        endcase
    end

endmodule

// ----- rtl/pid_bit_cell_tracker.sv -----
// Only one pulse is in work at a time: a new pulse transaction is accepted only once
// the previous result has left the clamp step. Eleven products go through the shared
// 25x17 multiplier (PID products, frequency gain, lower clamp limit), a further step
// drains its pipeline; the accept, wrap and integrate steps come before, sum and clamp after.
// A waiting result does not block the next transaction from being accepted; the new
// result then waits in the clamp step until the output register is free.
// Reset (aresetn low, synchronous) restores the configuration registers, the loop
// state and the handshake state to their defaults; the cell size returns to 2048.
module pid_bit_cell_tracker #(
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pbct_pkg::POS_W-1:0]           s_pulse_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pbct_pkg::POS_W-1:0]           m_new_cell_size,
    output logic [pbct_pkg::POS_W-1:0]           m_new_cell_center,
    output logic                                 m_size_clamped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbct_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbct_pkg::COEFF_W-1:0]         cfg_data
);
    import pbct_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;
    localparam int ACC_W = IW + 20;
    localparam int EXT_W = 2 * CHUNK_W;

    logic [POS_W-1:0] cell_size_ref_reg;
    logic [COEFF_W-1:0] freq_gain_reg;
    logic [COEFF_W-1:0] err_p_reg, err_i_reg, err_d_reg;
    logic [COEFF_W-1:0] diff_p_reg, diff_i_reg, diff_d_reg;

    logic [POS_W-1:0] last_pos_reg;
    logic signed [DP_W-1:0] last_dp_reg;
    logic signed [DP_W-1:0] last_ep_reg;
    logic signed [IW-1:0] diff_int_reg, diff_int_next;
    logic signed [IW-1:0] err_int_reg, err_int_next;
    logic [POS_W-1:0] cur_size_reg;

    logic [POS_W-1:0] pos_reg;
    logic signed [POS_W:0] dp_raw_reg;
    logic signed [DP_W-1:0] dp_reg, dp_next;
    logic signed [DP_W-1:0] ep_reg;
    logic signed [DD_W-1:0] dd_reg, ed_reg;
    logic signed [ACC_W-1:0] ns_reg;

    logic m_valid_reg;
    logic [POS_W-1:0] m_size_reg;
    logic m_clamped_reg;

    seq_ctrl_t ctrl;
    logic accept;
    logic out_free;

    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    logic signed [ACC_W-1:0] acc_f, acc_e, acc_g;
    logic [POS_W-1:0] lim_lo;

    logic signed [EXT_W-1:0] di_ext, ei_ext, f8_ext;
    logic signed [DP_W-1:0] dp2, size_s;
    logic signed [IW:0] di_sum, ei_sum;
    logic signed [IW-1:0] int_max, int_min;
    logic [POS_W:0] hi_wide;
    logic [POS_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lo_s, hi_s;
    logic [POS_W-1:0] size_res;
    logic clamped_res;

    assign accept = s_valid && ctrl.ready;
    assign out_free = !m_valid_reg || m_ready;

    pbct_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    pbct_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (ctrl.op),
        .opa     (opa),
        .opb     (opb),
        .acc_f   (acc_f),
        .acc_e   (acc_e),
        .acc_g   (acc_g),
        .lim_lo  (lim_lo)
    );

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_ref_reg <= CELL_SIZE_REF_RST;
            freq_gain_reg <= FREQ_GAIN_RST;
            err_p_reg <= ERR_P_RST;
            err_i_reg <= ERR_I_RST;
            err_d_reg <= ERR_D_RST;
            diff_p_reg <= DIFF_P_RST;
            diff_i_reg <= DIFF_I_RST;
            diff_d_reg <= DIFF_D_RST;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_CELL_SIZE_REF: cell_size_ref_reg <= cfg_data;
                REG_FREQ_GAIN:     freq_gain_reg <= cfg_data;
                REG_ERR_P:         err_p_reg <= cfg_data;
                REG_ERR_I:         err_i_reg <= cfg_data;
                REG_ERR_D:         err_d_reg <= cfg_data;
                REG_DIFF_P:        diff_p_reg <= cfg_data;
                REG_DIFF_I:        diff_i_reg <= cfg_data;
                REG_DIFF_D:        diff_d_reg <= cfg_data;
                default:           cell_size_ref_reg <= cell_size_ref_reg;
            endcase
        end
    end

    // Phase difference wraps by one cell when it lies beyond half a cell.
    always_comb begin
        dp2 = DP_W'(dp_raw_reg) <<< 1;
        size_s = $signed({2'b00, cur_size_reg});
        dp_next = DP_W'(dp_raw_reg);
        if (dp2 > size_s) begin
            dp_next = DP_W'(dp_raw_reg) - size_s;
        end else if (dp2 < -size_s) begin
            dp_next = DP_W'(dp_raw_reg) + size_s;
        end
    end

    // Saturating integrators.
    always_comb begin
        int_max = $signed({1'b0, {(IW - 1){1'b1}}});
        int_min = $signed({1'b1, {(IW - 1){1'b0}}});
        di_sum = (IW + 1)'(diff_int_reg) + (IW + 1)'(dp_reg);
        ei_sum = (IW + 1)'(err_int_reg) + (IW + 1)'(ep_reg);
        diff_int_next = di_sum[IW-1:0];
        if (di_sum[IW] != di_sum[IW-1]) begin
            diff_int_next = di_sum[IW] ? int_min : int_max;
        end
        err_int_next = ei_sum[IW-1:0];
        if (ei_sum[IW] != ei_sum[IW-1]) begin
            err_int_next = ei_sum[IW] ? int_min : int_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
            last_dp_reg <= '0;
            last_ep_reg <= '0;
            diff_int_reg <= '0;
            err_int_reg <= '0;
            cur_size_reg <= CELL_SIZE_REF_RST;
        end else begin
            if (ctrl.integ) begin
                last_dp_reg <= dp_reg;
                last_ep_reg <= ep_reg;
                diff_int_reg <= diff_int_next;
                err_int_reg <= err_int_next;
            end
            if (ctrl.commit) begin
                cur_size_reg <= size_res;
                last_pos_reg <= pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg <= s_pulse_position;
            dp_raw_reg <= $signed({1'b0, last_pos_reg}) - $signed({1'b0, s_pulse_position});
            ep_reg <= $signed({3'b000, cur_size_reg[POS_W-1:1]})
                    - $signed({2'b00, s_pulse_position});
        end
        if (ctrl.wrap) begin
            dp_reg <= dp_next;
            ed_reg <= DD_W'(ep_reg) - DD_W'(last_ep_reg);
        end
        if (ctrl.integ) begin
            dd_reg <= DD_W'(dp_reg) - DD_W'(last_dp_reg);
        end
        if (ctrl.sum) begin
            ns_reg <= $signed(ACC_W'(cell_size_ref_reg)) - (acc_g >>> G_SHIFT)
                    - (acc_e >>> F_SHIFT);
        end
    end

    // Wide operands enter the multiplier as a low unsigned and a high signed chunk.
    always_comb begin
        di_ext = EXT_W'(diff_int_reg);
        ei_ext = EXT_W'(err_int_reg);
        f8_ext = EXT_W'(acc_f >>> F_SHIFT);
        opa = '0;
        opb = '0;
        case (ctrl.op)
            OP_DP: begin
                opa = OPA_W'(dp_reg);
                opb = $signed({1'b0, diff_p_reg});
            end
            OP_DD: begin
                opa = OPA_W'(dd_reg);
                opb = $signed({1'b0, diff_d_reg});
            end
            OP_DILO: begin
                opa = $signed({1'b0, di_ext[CHUNK_W-1:0]});
                opb = $signed({1'b0, diff_i_reg});
            end
            OP_DIHI: begin
                opa = OPA_W'($signed(di_ext[EXT_W-1:CHUNK_W]));
                opb = $signed({1'b0, diff_i_reg});
            end
            OP_EP: begin
                opa = OPA_W'(ep_reg);
                opb = $signed({1'b0, err_p_reg});
            end
            OP_ED: begin
                opa = OPA_W'(ed_reg);
                opb = $signed({1'b0, err_d_reg});
            end
            OP_EILO: begin
                opa = $signed({1'b0, ei_ext[CHUNK_W-1:0]});
                opb = $signed({1'b0, err_i_reg});
            end
            OP_EIHI: begin
                opa = OPA_W'($signed(ei_ext[EXT_W-1:CHUNK_W]));
                opb = $signed({1'b0, err_i_reg});
            end
            OP_GLO: begin
                opa = $signed({1'b0, f8_ext[CHUNK_W-1:0]});
                opb = $signed({1'b0, freq_gain_reg});
            end
            OP_GHI: begin
                opa = OPA_W'($signed(f8_ext[EXT_W-1:CHUNK_W]));
                opb = $signed({1'b0, freq_gain_reg});
            end
            OP_LIM: begin
                opa = $signed(OPA_W'({cell_size_ref_reg, 1'b0}));
                opb = $signed(RECIP3);
            end
            default: opa = '0;
        endcase
    end

    // Clamp to [floor(2*ref/3), min(floor(3*ref/2), 65535)].
    always_comb begin
        hi_wide = {1'b0, cell_size_ref_reg} + {2'b00, cell_size_ref_reg[POS_W-1:1]};
        lim_hi = hi_wide[POS_W] ? SIZE_MAX : hi_wide[POS_W-1:0];
        lo_s = $signed(ACC_W'(lim_lo));
        hi_s = $signed(ACC_W'(lim_hi));
        size_res = ns_reg[POS_W-1:0];
        clamped_res = 1'b0;
        if (ns_reg < lo_s) begin
            size_res = lim_lo;
            clamped_res = 1'b1;
        end else if (ns_reg > hi_s) begin
            size_res = lim_hi;
            clamped_res = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_size_reg <= size_res;
            m_clamped_reg <= clamped_res;
        end
    end

    assign s_ready = ctrl.ready;
    assign m_valid = m_valid_reg;
    assign m_new_cell_size = m_size_reg;
    assign m_new_cell_center = {1'b0, m_size_reg[POS_W-1:1]};
    assign m_size_clamped = m_clamped_reg;

`ifndef SYNTHESIS
    // Only one pulse is in work at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("pulse accepted while the previous one is still in work");

    // A result is written only into a free output register.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_valid || m_ready))
        else $error("result overwrote an untaken output");

    // The tracked cell size moves only when a result is committed.
    a_size_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.commit |=> $stable(cur_size_reg))
        else $error("cell size changed outside commit");

    // A committed result matches what the output register then shows.
    a_out_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> (m_valid && m_new_cell_size == cur_size_reg))
        else $error("output size differs from tracked cell size");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import pbct_pkg::*;

    localparam int INTEG_W = 32;
    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SOAK_PULSES = 30;
    localparam int MAX_PRINTED = 50;
    localparam logic [POS_W-1:0] PULSE_ANCHOR = 16'h2000;

    typedef struct packed {
        logic [POS_W-1:0] cell_size;
        logic [POS_W-1:0] cell_center;
        logic             clamped;
    } cell_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [POS_W-1:0] s_pulse_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [POS_W-1:0] m_new_cell_size;
    logic [POS_W-1:0] m_new_cell_center;
    logic m_size_clamped;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CELL_SIZE_REF;
    logic [COEFF_W-1:0] cfg_data = '0;

    // Tracker copy: configuration and loop state as the block should hold them.
    logic [POS_W-1:0] size_ref;
    logic [COEFF_W-1:0] gain_q12, err_kp, err_ki, err_kd, diff_kp, diff_ki, diff_kd;
    logic [POS_W-1:0] prev_pos;
    logic [POS_W-1:0] cell_now;
    longint prev_diff, diff_acc, prev_err, err_acc;

    logic [POS_W-1:0] pending_pulses[$];
    cell_result_t expected_cells[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int pulses_taken = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int clamped_results = 0;
    longint err_bias = 0;

    pid_bit_cell_tracker #(
        .INTEGRAL_WIDTH(INTEG_W)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pulse_position (s_pulse_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_cell_size  (m_new_cell_size),
        .m_new_cell_center(m_new_cell_center),
        .m_size_clamped   (m_size_clamped),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic longint clip_integral(input longint acc);
        if (acc > INTEG_MAX) begin
            return INTEG_MAX;
        end
        if (acc < INTEG_MIN) begin
            return INTEG_MIN;
        end
        return acc;
    endfunction

    function automatic logic [COEFF_W-1:0] rand_word(input int unsigned max_val,
                                                    input int unsigned min_val = 0);
        return COEFF_W'($urandom_range(max_val, min_val));
    endfunction

    // Advances both PID loops by one flux pulse and returns the new cell.
    function automatic cell_result_t next_cell(input logic [POS_W-1:0] pos);
        longint pos_l, last_l, size_l, center_l, nominal, dp, dd, ep, ed;
        longint f24, e24, fterm, eterm, ns, lo, hi;
        cell_result_t r;
        pos_l = pos;
        last_l = prev_pos;
        size_l = cell_now;
        center_l = size_l >>> 1;
        nominal = size_ref;

        dp = last_l - pos_l;
        if (2 * dp > size_l) begin
            dp -= size_l;
        end else if (2 * dp < -size_l) begin
            dp += size_l;
        end
        dd = dp - prev_diff;
        diff_acc = clip_integral(diff_acc + dp);
        prev_diff = dp;

        ep = center_l - pos_l;
        ed = ep - prev_err;
        err_acc = clip_integral(err_acc + ep);
        prev_err = ep;

        f24 = dp * $signed({1'b0, diff_kp}) - dd * $signed({1'b0, diff_kd})
            + diff_acc * $signed({1'b0, diff_ki});
        e24 = ep * $signed({1'b0, err_kp}) - ed * $signed({1'b0, err_kd})
            + err_acc * $signed({1'b0, err_ki});
        fterm = ((f24 >>> F_SHIFT) * $signed({1'b0, gain_q12})) >>> G_SHIFT;
        eterm = e24 >>> F_SHIFT;

        ns = nominal - fterm - eterm;
        lo = (2 * nominal) / 3;
        hi = (3 * nominal) / 2;
        if (hi > longint'(SIZE_MAX)) begin
            hi = SIZE_MAX;
        end
        r.clamped = 1'b0;
        if (ns < lo) begin
            ns = lo;
            r.clamped = 1'b1;
        end else if (ns > hi) begin
            ns = hi;
            r.clamped = 1'b1;
        end

        cell_now = ns[POS_W-1:0];
        prev_pos = pos;
        r.cell_size = cell_now;
        r.cell_center = cell_now >> 1;
        return r;
    endfunction

    // Mostly pulses that land inside one cell, steered toward the side that
    // pulls the error integral back to zero; a few far-off or extreme ones.
    function automatic logic [POS_W-1:0] pick_pulse();
        int unsigned half, sel, p;
        half = size_ref >> 1;
        sel = $urandom_range(99);
        if (sel < 3) begin
            p = $urandom_range(65535);
        end else if (sel < 6) begin
            p = ($urandom_range(1) != 0) ? 65535 : 0;
        end else if (err_bias < 0) begin
            p = $urandom_range(half);
        end else begin
            p = half + $urandom_range(half);
        end
        err_bias += longint'(half) - longint'(p);
        return p[POS_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_ref = CELL_SIZE_REF_RST;
            gain_q12 = FREQ_GAIN_RST;
            err_kp = ERR_P_RST;
            err_ki = ERR_I_RST;
            err_kd = ERR_D_RST;
            diff_kp = DIFF_P_RST;
            diff_ki = DIFF_I_RST;
            diff_kd = DIFF_D_RST;
            prev_pos = '0;
            cell_now = CELL_SIZE_REF_RST;
            prev_diff = 0;
            diff_acc = 0;
            prev_err = 0;
            err_acc = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_CELL_SIZE_REF: size_ref = cfg_data;
                    REG_FREQ_GAIN:     gain_q12 = cfg_data;
                    REG_ERR_P:         err_kp = cfg_data;
                    REG_ERR_I:         err_ki = cfg_data;
                    REG_ERR_D:         err_kd = cfg_data;
                    REG_DIFF_P:        diff_kp = cfg_data;
                    REG_DIFF_I:        diff_ki = cfg_data;
                    REG_DIFF_D:        diff_kd = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_cells.push_back(next_cell(s_pulse_position));
                pulses_taken++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_pulse_position <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_pulses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_pulse_position <= pending_pulses.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The long hold-off is counted here so that the sender keeps offering
    // pulses while the result side is blocked.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_size_clamped) begin
                clamped_results++;
            end
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (size %0d)",
                                          m_new_cell_size));
            end else begin
                want = expected_cells.pop_front();
                if (m_new_cell_size !== want.cell_size) begin
                    report_mismatch($sformatf("cell size: got %0d, expected %0d",
                                              m_new_cell_size, want.cell_size));
                end
                if (m_new_cell_center !== want.cell_center) begin
                    report_mismatch($sformatf("cell center: got %0d, expected %0d",
                                              m_new_cell_center, want.cell_center));
                end
                if (m_size_clamped !== want.clamped) begin
                    report_mismatch($sformatf("clamp flag: got %0b, expected %0b",
                                              m_size_clamped, want.clamped));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                     quiet_cycles, expected_cells.size());
            $display("** pid_bit_cell_tracker: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (pending_pulses.size() != 0 || s_valid || expected_cells.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_pulse(input logic [POS_W-1:0] pos);
        pending_pulses.push_back(pos);
        wait_idle();
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [COEFF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    task automatic load_setting(input logic [15:0] nominal, input logic [15:0] gain,
                                input logic [15:0] ekp, input logic [15:0] eki,
                                input logic [15:0] ekd, input logic [15:0] dkp,
                                input logic [15:0] dki, input logic [15:0] dkd);
        write_reg(REG_CELL_SIZE_REF, nominal);
        write_reg(REG_FREQ_GAIN, gain);
        write_reg(REG_ERR_P, ekp);
        write_reg(REG_ERR_I, eki);
        write_reg(REG_ERR_D, ekd);
        write_reg(REG_DIFF_P, dkp);
        write_reg(REG_DIFF_I, dki);
        write_reg(REG_DIFF_D, dkd);
        settings_used++;
    endtask

    task automatic run_pulses(input int count, input bit with_hold);
        err_bias = err_acc;
        repeat (count) begin
            pending_pulses.push_back(pick_pulse());
        end
        if (with_hold) begin
            hold_req++;
        end
        wait_idle();
    endtask

    initial begin
        logic [POS_W-1:0] half_cell;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 16;
        recv_idle_pct = 81;

        // Directed pulses at the reset settings: field extremes, the exact cell
        // center, and both wrap thresholds on each side of the previous pulse.
        send_pulse(16'h0000);
        send_pulse(16'hFFFF);
        send_pulse(16'h0000);
        send_pulse(16'h8000);
        send_pulse(16'h7FFF);
        send_pulse(cell_now >> 1);
        for (int side = 0; side < 4; side++) begin
            send_pulse(PULSE_ANCHOR);
            half_cell = cell_now >> 1;
            send_pulse((side < 2) ? PULSE_ANCHOR - half_cell - POS_W'(side)
                                  : PULSE_ANCHOR + half_cell + POS_W'(side - 2));
        end
        send_pulse(prev_pos);
        send_pulse(16'h0001);
        send_pulse(16'hFFFE);

        // A new reference leaves the current cell alone until the next pulse.
        load_setting(16'd1024, rand_word(8192), rand_word(16384),
                     rand_word(4096), rand_word(4096), rand_word(2048),
                     rand_word(1024), rand_word(2048));
        run_pulses(130, 1'b1);

        send_idle_pct = 81;
        recv_idle_pct = 16;
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        run_pulses(60, 1'b0);
        // A zero reference pins both clamp limits at zero.
        load_setting(16'd0, rand_word(65535), rand_word(65535),
                     rand_word(65535), rand_word(65535), rand_word(65535),
                     rand_word(65535), rand_word(65535));
        run_pulses(20, 1'b0);
        load_setting(16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_pulses(20, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) begin
            load_setting(rand_word(65535, 256), rand_word(65535),
                         rand_word(65535), rand_word(4096),
                         rand_word(65535), rand_word(65535),
                         rand_word(4096), rand_word(65535));
            run_pulses(60, 1'b0);
        end

        // Push the error integral far negative with late pulses, then pull it back.
        load_setting(16'd256, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (SOAK_PULSES) begin
            pending_pulses.push_back(16'hFFFF);
        end
        repeat (20) begin
            pending_pulses.push_back(16'h0000);
        end
        wait_idle();

        repeat (24) @(posedge aclk);
        if (expected_cells.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
        end
        $display("Ran %0d pulses (%0d in the integrator soak) over %0d register settings,",
                 pulses_taken, SOAK_PULSES + 20, settings_used + 1);
        $display("%0d register writes, %0d clamped results, %0d mismatches.",
                 reg_writes, clamped_results, mismatches);
        if (mismatches == 0) begin
            $display("** pid_bit_cell_tracker: PASSED **");
        end else begin
            $display("** pid_bit_cell_tracker: FAILED **");
        end
        $finish;
    end

endmodule
